@@ design/cdri_pkg.sv @@
// ----------------------------------------------------------------------------
// cdri_pkg
// Types and constants for the cartridge DMA register interface.
// ----------------------------------------------------------------------------
package cdri_pkg;

   // Item kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   // Register offsets
   localparam logic [5:0] OFS_RAM_ADDR  = 6'h00;
   localparam logic [5:0] OFS_CART_ADDR = 6'h04;
   localparam logic [5:0] OFS_XFER_LEN  = 6'h08;
   localparam logic [5:0] OFS_COPY_LEN  = 6'h0C;
   localparam logic [5:0] OFS_STATUS    = 6'h10;
   localparam logic [5:0] OFS_D1_LAT    = 6'h14;
   localparam logic [5:0] OFS_D1_PWD    = 6'h18;
   localparam logic [5:0] OFS_D1_PGS    = 6'h1C;
   localparam logic [5:0] OFS_D1_RLS    = 6'h20;
   localparam logic [5:0] OFS_D2_LAT    = 6'h24;
   localparam logic [5:0] OFS_D2_PWD    = 6'h28;
   localparam logic [5:0] OFS_D2_PGS    = 6'h2C;
   localparam logic [5:0] OFS_D2_RLS    = 6'h30;

   // DMA commands
   localparam logic [2:0] CMD_NONE       = 3'd0;
   localparam logic [2:0] CMD_SRAM_XFER  = 3'd1;
   localparam logic [2:0] CMD_FLASH_XFER = 3'd2;
   localparam logic [2:0] CMD_SRAM_COPY  = 3'd3;
   localparam logic [2:0] CMD_FLASH_COPY = 3'd4;
   localparam logic [2:0] CMD_ROM_COPY   = 3'd5;

   // Backup storage kinds
   localparam logic [1:0] STORAGE_SRAM  = 2'd1;
   localparam logic [1:0] STORAGE_FLASH = 2'd2;

   // Cartridge address windows
   localparam logic [31:0] BACKUP_LO = 32'h0800_0000;
   localparam logic [31:0] BACKUP_HI = 32'h0FFF_FFFF;
   localparam logic [31:0] ROM_LO    = 32'h1000_0000;
   localparam logic [31:0] ROM_HI    = 32'h1FBF_FFFF;

   // Status bit that clears the interrupt
   localparam int STATUS_CLR_BIT = 1;

   // Configuration register index
   localparam logic CSR_STORAGE_KIND = 1'b0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  reg_offset;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] read_data;
      logic [2:0]  dma_command;
      logic [23:0] dma_ram_address;
      logic [31:0] dma_cart_address;
      logic [24:0] dma_length;
      logic        raise_interrupt;
      logic        clear_interrupt;
   } rsp_type;

endpackage

@@ design/cartridge_dma_register_interface_unit.sv @@
// ----------------------------------------------------------------------------
// cartridge_dma_register_interface_unit
// Register block of a cartridge DMA controller with command issue.
// ----------------------------------------------------------------------------
// Each request (register read, register write or ROM DMA completion) yields
// exactly one response in the cycle after it is accepted. The register update,
// window compare and command build sit between the request handshake and the
// response register, so a new request is taken every cycle as long as the
// response register is empty or being drained in the same cycle. The user sets
// backup storage kind (APB, byte address 0) only while idle, unenforced.
module cartridge_dma_register_interface_unit
   import cdri_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [1:0]  storage_kind_ff;
   logic [23:0] ram_address_ff,     ram_address_in;
   logic [31:0] cart_address_ff,    cart_address_in;
   logic [23:0] transfer_length_ff, transfer_length_in;
   logic [23:0] copy_length_ff,     copy_length_in;
   logic [1:0]  busy_bits_ff,       busy_bits_in;
   logic [7:0]  latency_ff [2],     latency_in [2];
   logic [7:0]  pulse_width_ff [2], pulse_width_in [2];
   logic [3:0]  page_size_ff [2],   page_size_in [2];
   logic        release_ff [2],     release_in [2];

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic        in_backup;
   logic        in_rom;
   logic        mapped;
   logic [31:0] rd_value;
   logic [23:0] len_value;
   logic [24:0] len_plus_one;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_STORAGE_KIND) ? {30'd0, storage_kind_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         storage_kind_ff <= '0;
      end else if (psel && penable && pwrite && paddr[2] == CSR_STORAGE_KIND) begin
         storage_kind_ff <= pwdata[1:0];
      end
   end

   assign in_backup    = cart_address_ff >= BACKUP_LO && cart_address_ff <= BACKUP_HI;
   assign in_rom       = cart_address_ff >= ROM_LO && cart_address_ff <= ROM_HI;
   assign len_value    = req_data.write_data[23:0];
   assign len_plus_one = {1'b0, len_value} + 25'd1;

   // register read mux
   always_comb begin
      mapped   = 1'b1;
      rd_value = '0;
      unique case (req_data.reg_offset)
         OFS_RAM_ADDR:  rd_value = {8'd0, ram_address_ff};
         OFS_CART_ADDR: rd_value = cart_address_ff;
         OFS_XFER_LEN:  rd_value = {8'd0, transfer_length_ff};
         OFS_COPY_LEN:  rd_value = {8'd0, copy_length_ff};
         OFS_STATUS:    rd_value = {30'd0, busy_bits_ff};
         OFS_D1_LAT:    rd_value = {24'd0, latency_ff[0]};
         OFS_D1_PWD:    rd_value = {24'd0, pulse_width_ff[0]};
         OFS_D1_PGS:    rd_value = {28'd0, page_size_ff[0]};
         OFS_D1_RLS:    rd_value = {31'd0, release_ff[0]};
         OFS_D2_LAT:    rd_value = {24'd0, latency_ff[1]};
         OFS_D2_PWD:    rd_value = {24'd0, pulse_width_ff[1]};
         OFS_D2_PGS:    rd_value = {28'd0, page_size_ff[1]};
         OFS_D2_RLS:    rd_value = {31'd0, release_ff[1]};
         default:       mapped   = 1'b0;
      endcase
   end

   // next state and response
   always_comb begin
      ram_address_in     = ram_address_ff;
      cart_address_in    = cart_address_ff;
      transfer_length_in = transfer_length_ff;
      copy_length_in     = copy_length_ff;
      busy_bits_in       = busy_bits_ff;
      latency_in         = latency_ff;
      pulse_width_in     = pulse_width_ff;
      page_size_in       = page_size_ff;
      release_in         = release_ff;
      rsp_in             = '0;

      unique case (req_data.kind)
         KIND_READ: begin
            if (mapped) begin
               rsp_in.ok        = 1'b1;
               rsp_in.read_data = rd_value;
            end
         end
         KIND_WRITE: begin
            rsp_in.ok = mapped;
            unique case (req_data.reg_offset)
               OFS_RAM_ADDR:  ram_address_in  = req_data.write_data[23:0];
               OFS_CART_ADDR: cart_address_in = req_data.write_data;
               OFS_XFER_LEN: begin
                  transfer_length_in     = len_value;
                  rsp_in.raise_interrupt = 1'b1;
                  if (in_backup && storage_kind_ff == STORAGE_SRAM) begin
                     rsp_in.dma_command = CMD_SRAM_XFER;
                  end else if (in_backup && storage_kind_ff == STORAGE_FLASH) begin
                     rsp_in.dma_command = CMD_FLASH_XFER;
                  end
               end
               OFS_COPY_LEN: begin
                  copy_length_in = len_value;
                  if (in_backup) begin
                     rsp_in.raise_interrupt = 1'b1;
                     if (storage_kind_ff == STORAGE_SRAM) begin
                        rsp_in.dma_command = CMD_SRAM_COPY;
                     end else if (storage_kind_ff == STORAGE_FLASH) begin
                        rsp_in.dma_command = CMD_FLASH_COPY;
                     end
                  end else if (in_rom) begin
                     // interrupt waits for the completion item
                     busy_bits_in       = 2'b11;
                     rsp_in.dma_command = CMD_ROM_COPY;
                  end else begin
                     rsp_in.raise_interrupt = 1'b1;
                  end
               end
               OFS_STATUS: rsp_in.clear_interrupt = req_data.write_data[STATUS_CLR_BIT];
               OFS_D1_LAT: latency_in[0]     = req_data.write_data[7:0];
               OFS_D1_PWD: pulse_width_in[0] = req_data.write_data[7:0];
               OFS_D1_PGS: page_size_in[0]   = req_data.write_data[3:0];
               OFS_D1_RLS: release_in[0]     = req_data.write_data[0];
               OFS_D2_LAT: latency_in[1]     = req_data.write_data[7:0];
               OFS_D2_PWD: pulse_width_in[1] = req_data.write_data[7:0];
               OFS_D2_PGS: page_size_in[1]   = req_data.write_data[3:0];
               OFS_D2_RLS: release_in[1]     = req_data.write_data[0];
               default: ;
            endcase
            if (rsp_in.dma_command != CMD_NONE) begin
               rsp_in.dma_ram_address  = ram_address_ff;
               rsp_in.dma_cart_address = cart_address_ff;
               rsp_in.dma_length       = len_plus_one;
            end
         end
         KIND_DONE: begin
            busy_bits_in           = '0;
            rsp_in.ok              = 1'b1;
            rsp_in.raise_interrupt = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_address_ff     <= '0;
         cart_address_ff    <= '0;
         transfer_length_ff <= '0;
         copy_length_ff     <= '0;
         busy_bits_ff       <= '0;
         latency_ff         <= '{default: '0};
         pulse_width_ff     <= '{default: '0};
         page_size_ff       <= '{default: '0};
         release_ff         <= '{default: '0};
      end else if (accept) begin
         ram_address_ff     <= ram_address_in;
         cart_address_ff    <= cart_address_in;
         transfer_length_ff <= transfer_length_in;
         copy_length_ff     <= copy_length_in;
         busy_bits_ff       <= busy_bits_in;
         latency_ff         <= latency_in;
         pulse_width_ff     <= pulse_width_in;
         page_size_ff       <= page_size_in;
         release_ff         <= release_in;
      end
   end

   // response register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
